@@ hdl/salc_pkg.sv @@
// Package for the set-associative LRU cache: sizes, field widths, codes, row layout
// and controller/datapath handshake structs.
// No dependencies.
package salc_pkg;

    localparam int MAX_SETS   = 256;
    localparam int MAX_WAYS   = 8;
    localparam int TAG_W      = 64;
    localparam int ADDR_W     = 64;
    localparam int SET_BITS   = $clog2(MAX_SETS);
    localparam int SET_IDX_W  = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_IDX_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W      = 3;
    localparam int AGE_MAX    = 7;
    localparam int OFF_MAX    = 16;
    localparam int TOTAL_W    = 32;
    localparam int HITS_W     = 2;

    localparam int OPCODE_W   = 2;
    localparam int SET_CFG_W  = 4;
    localparam int OFF_CFG_W  = 5;
    localparam int WAYS_CFG_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_IFETCH = 2'd0,
        OP_LOAD   = 2'd1,
        OP_STORE  = 2'd2,
        OP_MODIFY = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS = 2'd0,
        CFG_OFF_BITS = 2'd1,
        CFG_WAYS     = 2'd2
    } t_cfg_index;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [MAX_WAYS-1:0]                valid;
        logic [MAX_WAYS-1:0][AGE_W-1:0]     age;
        logic [MAX_WAYS-1:0][TAG_W-1:0]     tag;
    } t_row;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

@@ hdl/salc_if.sv @@
// Channel interfaces of the cache: access request, result and configuration write.
// Depends on salc_pkg.
interface salc_req_if import salc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [ADDR_W-1:0]   address;

    modport source (output valid, opcode, address, input ready);
    modport sink   (input valid, opcode, address, output ready);
endinterface

interface salc_rsp_if import salc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [HITS_W-1:0]  hit_count;
    logic               missed;
    logic               evicted;
    logic [TOTAL_W-1:0] total_hits;
    logic [TOTAL_W-1:0] total_misses;
    logic [TOTAL_W-1:0] total_evictions;

    modport source (output valid, hit_count, missed, evicted, total_hits, total_misses,
                    total_evictions, input ready);
    modport sink   (input valid, hit_count, missed, evicted, total_hits, total_misses,
                    total_evictions, output ready);
endinterface

interface salc_cfg_if import salc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/set_assoc_lru_cache_model.sv @@
// Top level of the set-associative cache with true LRU replacement.
// Depends on salc_pkg, salc_if, salc_ctrl and salc_dp.
//
// Usage:
//   i_req carries one trace access (opcode, byte address); a transfer takes place
//   when valid and ready are both high. Instruction fetches change nothing.
//   o_rsp returns exactly one result per access: hits of this access, miss and
//   eviction flags, and saturating running totals of hits, misses and evictions.
//   i_cfg writes set index bits (index 0), block offset bits (1) and ways in use
//   (2), always ready; user writes only while no access is in flight (unenforced).
// Timing:
//   An accepted access reads its set row in the accept cycle; in the EXEC state,
//   once the result register is free, it updates the row and loads the result
//   register. One access is in flight at a time; a new access is taken only after
//   the previous one has updated its set row and loaded its result.
// Reset and stall:
//   Synchronous reset empties the cache through per-set valid flags at once and
//   clears the totals; the configuration returns to 4, 4 and 1.
//   While the receiver stalls, the result holds; a next access may be taken and
//   waits in its update cycle until the result register frees.
module set_assoc_lru_cache_model import salc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    salc_req_if.sink   i_req,
    salc_rsp_if.source o_rsp,
    salc_cfg_if.sink   i_cfg
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign i_cfg.ready = 1'b1;

    salc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    salc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_opcode          (i_req.opcode),
        .i_address         (i_req.address),
        .i_rsp_ready       (o_rsp.ready),
        .o_rsp_valid       (o_rsp.valid),
        .o_hit_count       (o_rsp.hit_count),
        .o_missed          (o_rsp.missed),
        .o_evicted         (o_rsp.evicted),
        .o_total_hits      (o_rsp.total_hits),
        .o_total_misses    (o_rsp.total_misses),
        .o_total_evictions (o_rsp.total_evictions)
    );

endmodule

@@ hdl/salc_ctrl.sv @@
// Controller of the cache: accepts one access, then commits its set update and result.
// Depends on salc_pkg.
module salc_ctrl import salc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
        endcase
    end

endmodule

@@ hdl/salc_dp.sv @@
// Datapath of the cache: configuration registers, set memory, lookup and LRU update,
// running totals and the result register. Depends on salc_pkg.
module salc_dp import salc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic                  i_rsp_ready,
    output logic                  o_rsp_valid,
    output logic [HITS_W-1:0]     o_hit_count,
    output logic                  o_missed,
    output logic                  o_evicted,
    output logic [TOTAL_W-1:0]    o_total_hits,
    output logic [TOTAL_W-1:0]    o_total_misses,
    output logic [TOTAL_W-1:0]    o_total_evictions
);

    logic [SET_CFG_W-1:0]  r_set_bits;
    logic [OFF_CFG_W-1:0]  r_off_bits;
    logic [WAYS_CFG_W-1:0] r_ways;

    logic [SET_CFG_W-1:0]  eff_set;
    logic [OFF_CFG_W-1:0]  eff_off;
    logic [WAYS_CFG_W-1:0] eff_ways;

    logic [ADDR_W-1:0]     shifted;
    logic [ADDR_W-1:0]     tag_full;
    logic [SET_BITS:0]     set_span;
    logic [SET_IDX_W-1:0]  set_idx;

    t_row                  r_mem [MAX_SETS];
    logic [MAX_SETS-1:0]   r_row_ok;
    t_row                  r_rd;
    logic                  r_rd_ok;
    t_opcode               r_op;
    logic [TAG_W-1:0]      r_tag;
    logic [SET_IDX_W-1:0]  r_set;

    t_row                  n_row;
    logic                  hit;
    logic                  has_inv;
    logic [HITS_W-1:0]     n_hits;
    logic                  n_miss;
    logic                  n_evict;
    logic                  active;

    logic [TOTAL_W-1:0]    r_total_hits;
    logic [TOTAL_W-1:0]    r_total_misses;
    logic [TOTAL_W-1:0]    r_total_evictions;
    logic [TOTAL_W-1:0]    n_total_hits;
    logic [TOTAL_W-1:0]    n_total_misses;
    logic [TOTAL_W-1:0]    n_total_evictions;
    logic [TOTAL_W+1:0]    hit_sum;

    logic                  r_out_valid;
    logic [HITS_W-1:0]     r_hit_count;
    logic                  r_missed;
    logic                  r_evicted;

    // effective configuration
    always_comb begin
        eff_set  = (r_set_bits > SET_CFG_W'(SET_BITS)) ? SET_CFG_W'(SET_BITS) : r_set_bits;
        eff_off  = (r_off_bits > OFF_CFG_W'(OFF_MAX)) ? OFF_CFG_W'(OFF_MAX) : r_off_bits;
        if (r_ways == '0) begin
            eff_ways = WAYS_CFG_W'(1);
        end else if (r_ways > WAYS_CFG_W'(MAX_WAYS)) begin
            eff_ways = WAYS_CFG_W'(MAX_WAYS);
        end else begin
            eff_ways = r_ways;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= SET_CFG_W'(4);
            r_off_bits <= OFF_CFG_W'(4);
            r_ways     <= WAYS_CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SET_BITS: r_set_bits <= i_cfg_data[SET_CFG_W-1:0];
                CFG_OFF_BITS: r_off_bits <= i_cfg_data[OFF_CFG_W-1:0];
                CFG_WAYS:     r_ways     <= i_cfg_data[WAYS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // address split
    always_comb begin
        shifted  = i_address >> eff_off;
        tag_full = shifted >> eff_set;
        set_span = (SET_BITS + 1)'((SET_BITS + 1)'(1) << eff_set) - (SET_BITS + 1)'(1);
        set_idx  = SET_IDX_W'(shifted & ADDR_W'(set_span));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd  <= r_mem[set_idx];
            r_op  <= t_opcode'(i_opcode);
            r_tag <= tag_full[TAG_W-1:0];
            r_set <= set_idx;
        end
        if (active) begin
            r_mem[r_set] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_rd_ok <= r_row_ok[set_idx];
            end
            if (active) begin
                r_row_ok[r_set] <= 1'b1;
            end
        end
    end

    // lookup and LRU update
    always_comb begin
        logic [MAX_WAYS-1:0]            in_use;
        logic [MAX_WAYS-1:0]            valid_v;
        logic [MAX_WAYS-1:0][AGE_W-1:0] age_v;
        logic [WAY_IDX_W-1:0]           hit_way;
        logic [WAY_IDX_W-1:0]           inv_way;
        logic [WAY_IDX_W-1:0]           victim;
        logic [WAY_IDX_W-1:0]           way;
        logic [AGE_W:0]                 limit;

        n_row   = r_rd;
        valid_v = r_rd_ok ? r_rd.valid : '0;
        age_v   = r_rd_ok ? r_rd.age : '0;
        hit     = 1'b0;
        has_inv = 1'b0;
        hit_way = '0;
        inv_way = '0;
        victim  = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            in_use[i] = (WAYS_CFG_W'(i) < eff_ways);
        end
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (in_use[i] && valid_v[i] && r_rd.tag[i] == r_tag) begin
                hit     = 1'b1;
                hit_way = WAY_IDX_W'(i);
            end
            if (in_use[i] && !valid_v[i]) begin
                has_inv = 1'b1;
                inv_way = WAY_IDX_W'(i);
            end
        end
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (in_use[i] && age_v[i] > age_v[victim]) begin
                victim = WAY_IDX_W'(i);
            end
        end
        if (hit) begin
            way   = hit_way;
            limit = {1'b0, age_v[hit_way]};
        end else if (has_inv) begin
            way   = inv_way;
            limit = (AGE_W + 1)'(AGE_MAX + 1);
        end else begin
            way   = victim;
            limit = {1'b0, age_v[victim]};
        end
        n_row.valid = valid_v;
        n_row.age   = age_v;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (in_use[i] && WAY_IDX_W'(i) != way && valid_v[i]
                && {1'b0, age_v[i]} < limit && age_v[i] != AGE_W'(AGE_MAX)) begin
                n_row.age[i] = age_v[i] + AGE_W'(1);
            end
        end
        n_row.age[way] = '0;
        if (!hit) begin
            n_row.valid[way] = 1'b1;
            n_row.tag[way]   = r_tag;
        end

        active  = i_cmd.commit && (r_op != OP_IFETCH);
        n_miss  = (r_op != OP_IFETCH) && !hit;
        n_evict = n_miss && !has_inv;
        n_hits  = HITS_W'((r_op != OP_IFETCH) && hit) + HITS_W'(r_op == OP_MODIFY);
    end

    // saturating totals
    always_comb begin
        hit_sum = (TOTAL_W + 2)'(r_total_hits) + (TOTAL_W + 2)'(n_hits);
        n_total_hits = (hit_sum[TOTAL_W+1:TOTAL_W] != '0) ? '1 : hit_sum[TOTAL_W-1:0];
        n_total_misses = (n_miss && r_total_misses != '1) ?
                         r_total_misses + TOTAL_W'(1) : r_total_misses;
        n_total_evictions = (n_evict && r_total_evictions != '1) ?
                            r_total_evictions + TOTAL_W'(1) : r_total_evictions;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_hits      <= '0;
            r_total_misses    <= '0;
            r_total_evictions <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_total_hits      <= n_total_hits;
                r_total_misses    <= n_total_misses;
                r_total_evictions <= n_total_evictions;
                r_out_valid       <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit_count <= n_hits;
            r_missed    <= n_miss;
            r_evicted   <= n_evict;
        end
    end

    assign o_status.out_busy  = r_out_valid && !i_rsp_ready;
    assign o_rsp_valid        = r_out_valid;
    assign o_hit_count        = r_hit_count;
    assign o_missed           = r_missed;
    assign o_evicted          = r_evicted;
    assign o_total_hits       = r_total_hits;
    assign o_total_misses     = r_total_misses;
    assign o_total_evictions  = r_total_evictions;

endmodule
